// ----- hw/rtl/lasc_pkg.sv -----
// Package for the lookahead steering controller: shared types, constants and the
// CORDIC arctangent table. Used by the controller, datapath and top level; depends on nothing.
`default_nettype none
package lasc_pkg;

    localparam int MaxPathPoints = 256;
    localparam int CordicIters   = 15;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_MAX_STEER = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_CRUISE    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic query_start;  // latch pose, clear best trackers
        logic rd_issue;     // read waypoint at scan index
        logic pt_load;      // load registered waypoint, start CORDIC
        logic cordic_step;  // one CORDIC iteration
        logic pt_judge;     // compare and update best trackers
        logic fin_load;     // load chosen waypoint difference
        logic fin_scale;    // heading error magnitude and rate clamp
        logic fin_mul;      // speed scale and gain multiply
        logic fin_out;      // form result
    } lasc_cmd_t;

    typedef struct packed {
        logic have_any;
    } lasc_sts_t;

    // CORDIC angle table, atan(2^-i) in binary angle units.
    function automatic logic signed [15:0] atan_entry(input logic [3:0] i);
        logic signed [15:0] r;
        begin
            unique case (i)
                4'd0: r = 16'sd8192;
                4'd1: r = 16'sd4836;
                4'd2: r = 16'sd2555;
                4'd3: r = 16'sd1297;
                4'd4: r = 16'sd651;
                4'd5: r = 16'sd326;
                4'd6: r = 16'sd163;
                4'd7: r = 16'sd81;
                4'd8: r = 16'sd41;
                4'd9: r = 16'sd20;
                4'd10: r = 16'sd10;
                4'd11: r = 16'sd5;
                4'd12: r = 16'sd3;
                4'd13: r = 16'sd1;
                4'd14: r = 16'sd1;
                default: r = 16'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lasc_ctrl.sv -----
// Controller state machine of the lookahead steering controller.
// Depends on lasc_pkg; sequences the datapath over one query.
`default_nettype none
module lasc_ctrl #(
    parameter int IDX_W = 8,
    parameter int LEN_W = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [LEN_W-1:0]      path_len,
    input  wire lasc_pkg::lasc_sts_t   sts,
    input  wire logic                  out_taken,
    output lasc_pkg::lasc_cmd_t        cmd,
    output logic [IDX_W-1:0]           scan_idx,
    output logic                       busy,
    output logic                       out_valid
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_CORD  = 10'b0000001000,
        S_JUDGE = 10'b0000010000,
        S_FLOAD = 10'b0000100000,
        S_FCORD = 10'b0001000000,
        S_FSCL  = 10'b0010000000,
        S_FMUL  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [3:0] it_reg, it_next;
    logic ov_reg, ov_next;

    assign scan_idx  = cnt_reg[IDX_W-1:0];
    assign busy      = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        ov_next    = ov_reg && !out_taken;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !ov_reg)
                begin
                    cmd.query_start = 1'b1;
                    cnt_next = '0;
                    state_next = (path_len == '0) ? S_FLOAD : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.pt_load = 1'b1;
                it_next = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.cordic_step = 1'b1;
                it_next = it_reg + 4'd1;
                if (it_reg == 4'(lasc_pkg::CordicIters - 1))
                    state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.pt_judge = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                state_next = (cnt_reg + 1'b1 >= path_len) ? S_FLOAD : S_READ;
            end
            S_FLOAD:
            begin
                cmd.fin_load = 1'b1;
                it_next = '0;
                state_next = S_FCORD;
            end
            S_FCORD:
            begin
                cmd.cordic_step = 1'b1;
                it_next = it_reg + 4'd1;
                if (it_reg == 4'(lasc_pkg::CordicIters - 1))
                    state_next = S_FSCL;
            end
            S_FSCL:
            begin
                cmd.fin_scale = 1'b1;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.fin_mul = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.fin_out = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            it_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            it_reg    <= it_next;
            ov_reg    <= ov_next;
        end
    end

    logic unused_sts;
    assign unused_sts = sts.have_any;

endmodule
`default_nettype wire

// ----- hw/rtl/lasc_datapath.sv -----
// Datapath of the lookahead steering controller: waypoint memories, distance
// test, shared CORDIC unit, best trackers and the command arithmetic. Uses lasc_pkg.
`default_nettype none
module lasc_datapath #(
    parameter int DEPTH = lasc_pkg::MaxPathPoints,
    parameter int IDX_W = 8
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic signed [23:0]   wr_x,
    input  wire logic signed [23:0]   wr_y,
    input  wire logic [IDX_W-1:0]     scan_idx,
    input  wire logic signed [23:0]   robot_x,
    input  wire logic signed [23:0]   robot_y,
    input  wire logic signed [15:0]   robot_heading,
    input  wire logic [23:0]          lookahead,
    input  wire logic [15:0]          max_steer,
    input  wire logic [15:0]          gain,
    input  wire logic [15:0]          cruise,
    input  wire lasc_pkg::lasc_cmd_t  cmd,
    input  wire logic                 rst_n,
    output lasc_pkg::lasc_sts_t       sts,
    output logic                      res_found,
    output logic [7:0]                res_index,
    output logic [15:0]               res_speed,
    output logic signed [18:0]        res_rate
);

    // Waypoint memories.
    logic signed [23:0] mem_x [DEPTH];
    logic signed [23:0] mem_y [DEPTH];
    logic signed [23:0] rdx_reg, rdy_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        if (cmd.rd_issue)
        begin
            rdx_reg <= mem_x[scan_idx];
            rdy_reg <= mem_y[scan_idx];
        end
    end

    // Pose and square of lookahead, latched at query start.
    logic signed [23:0] rx_reg, ry_reg;
    logic signed [15:0] th_reg;
    logic [47:0] l2_reg;
    // Best trackers.
    logic have_any_reg, have_fwd_reg;
    logic [48:0] best_any_d_reg, best_fwd_d_reg;
    logic [IDX_W-1:0] best_any_reg, best_fwd_reg;
    logic signed [24:0] bdx_any_reg, bdy_any_reg, bdx_fwd_reg, bdy_fwd_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    // Current point: differences and squared distance.
    logic signed [24:0] dx_reg, dy_reg;
    logic [48:0] d2_reg;
    // CORDIC state.
    logic signed [26:0] cx_reg, cy_reg;
    logic signed [15:0] ca_reg;
    logic [3:0] ci_reg;

    logic signed [24:0] dx_w, dy_w;
    assign dx_w = 25'(rdx_reg) - 25'(rx_reg);
    assign dy_w = 25'(rdy_reg) - 25'(ry_reg);

    // Squares of the differences, at full width.
    logic signed [49:0] sqx_w, sqy_w;
    assign sqx_w = 50'(dx_w) * 50'(dx_w);
    assign sqy_w = 50'(dy_w) * 50'(dy_w);

    // Pre-rotation into the right half plane.
    function automatic logic [69:0] prerot(input logic signed [24:0] x,
                                           input logic signed [24:0] y);
        logic signed [26:0] px, py;
        logic signed [15:0] pa;
        begin
            px = 27'(x); py = 27'(y); pa = '0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    px = 27'(y); py = -27'(x); pa = 16'sd16384;
                end
                else
                begin
                    px = -27'(y); py = 27'(x); pa = -16'sd16384;
                end
            end
            return {px, py, pa};
        end
    endfunction

    // One CORDIC iteration; arithmetic shifts floor.
    logic signed [26:0] sx, sy;
    logic signed [15:0] at;
    assign sx = cx_reg >>> ci_reg;
    assign sy = cy_reg >>> ci_reg;
    assign at = lasc_pkg::atan_entry(ci_reg);

    // Judge terms.
    logic signed [15:0] diff;
    logic fwd;
    logic ge_l2;
    assign diff  = ca_reg - th_reg;
    assign fwd   = (diff > -16'sd16384) && (diff < 16'sd16384);
    assign ge_l2 = d2_reg >= {1'b0, l2_reg};

    // Final stage registers.
    logic [15:0] ae_reg;
    logic [16:0] scale_reg;
    logic signed [16:0] ec_reg;
    logic [31:0] spd_reg;
    logic signed [33:0] eg_reg;
    logic [16:0] ae_w;
    logic [20:0] q5;
    logic [16:0] sc_w;
    logic [16:0] clampv;
    logic signed [17:0] ecl;
    logic signed [54:0] rate_w;

    // floor(ae*8/5) by reciprocal: ae*8 <= 2^18, and (v*419431)>>21 is exact there.
    logic [18:0] v8;
    logic [37:0] qm;
    assign ae_w = (diff < 0) ? 17'(-18'(diff)) : 17'(diff);
    assign v8 = 19'(ae_reg) << 3;
    assign qm = 38'(v8) * 38'd419431;
    assign q5 = 21'(qm >> 21);
    assign sc_w = (32'd65536 - 32'(q5) < 32'd13107) ? 17'd13107
                                                    : 17'(32'd65536 - 32'(q5));
    assign clampv = (max_steer > 16'd32768) ? 17'd32768 : 17'(max_steer);
    assign rate_w = 55'(eg_reg) * 55'sd205887 + (55'sd1 <<< 30);

    logic signed [17:0] e_s;
    assign e_s = 18'(signed'(diff));
    assign ecl = (e_s > signed'({1'b0, clampv})) ? signed'({1'b0, clampv})
               : (e_s < -signed'({1'b0, clampv})) ? -signed'({1'b0, clampv}) : e_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_any_reg <= 1'b0;
            have_fwd_reg <= 1'b0;
        end
        else if (cmd.query_start)
        begin
            have_any_reg <= 1'b0;
            have_fwd_reg <= 1'b0;
        end
        else if (cmd.pt_judge && ge_l2)
        begin
            if (!have_any_reg || d2_reg < best_any_d_reg)
                have_any_reg <= 1'b1;
            if (fwd && (!have_fwd_reg || d2_reg < best_fwd_d_reg))
                have_fwd_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            rx_reg <= robot_x; ry_reg <= robot_y; th_reg <= robot_heading;
            l2_reg <= 48'(lookahead) * 48'(lookahead);
            cur_idx_reg <= '0;
        end
        if (cmd.pt_load)
        begin
            dx_reg <= dx_w; dy_reg <= dy_w;
            d2_reg <= 49'(sqx_w + sqy_w);
            {cx_reg, cy_reg, ca_reg} <= prerot(dx_w, dy_w);
            ci_reg <= '0;
        end
        if (cmd.fin_load)
        begin
            if (have_fwd_reg)
                {cx_reg, cy_reg, ca_reg} <= prerot(bdx_fwd_reg, bdy_fwd_reg);
            else
                {cx_reg, cy_reg, ca_reg} <= prerot(bdx_any_reg, bdy_any_reg);
            ci_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + sy; cy_reg <= cy_reg - sx; ca_reg <= ca_reg + at;
            end
            else if (cy_reg < 0)
            begin
                cx_reg <= cx_reg - sy; cy_reg <= cy_reg + sx; ca_reg <= ca_reg - at;
            end
            ci_reg <= ci_reg + 4'd1;
        end
        if (cmd.pt_judge)
        begin
            cur_idx_reg <= cur_idx_reg + 1'b1;
            if (ge_l2)
            begin
                if (!have_any_reg || d2_reg < best_any_d_reg)
                begin
                    best_any_d_reg <= d2_reg; best_any_reg <= cur_idx_reg;
                    bdx_any_reg <= dx_reg; bdy_any_reg <= dy_reg;
                end
                if (fwd && (!have_fwd_reg || d2_reg < best_fwd_d_reg))
                begin
                    best_fwd_d_reg <= d2_reg; best_fwd_reg <= cur_idx_reg;
                    bdx_fwd_reg <= dx_reg; bdy_fwd_reg <= dy_reg;
                end
            end
        end
        if (cmd.fin_scale)
        begin
            ae_reg <= ae_w[15:0] | {16{ae_w[16]}} & 16'h8000;
            ec_reg <= 17'(ecl);
        end
        if (cmd.fin_mul)
        begin
            scale_reg <= sc_w;
            eg_reg <= 34'(ec_reg) * 34'(signed'({1'b0, gain}));
        end
        if (cmd.fin_out)
        begin
            res_found <= have_any_reg;
            res_index <= have_any_reg
                       ? 8'(have_fwd_reg ? best_fwd_reg : best_any_reg) : 8'd0;
            spd_reg   <= 32'(cruise) * 32'(scale_reg);
            res_rate  <= have_any_reg ? 19'(rate_w >>> 31) : '0;
        end
    end

    logic found_d;
    always_ff @(posedge clk)
    begin
        found_d <= have_any_reg;
    end
    assign res_speed = found_d ? spd_reg[31:16] : 16'd0;
    assign sts.have_any = have_any_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/lookahead_steering_controller_core.sv -----
// Lookahead steering controller: top level with stream ports and register port.
// A query steps through each stored waypoint (read, load, 15 CORDIC iterations
// and a compare) and then through the chosen point (load, 15 CORDIC iterations,
// scale, multiply, output). One item is in work at a time; the result register
// holds until taken. Reset restores register defaults and empties the path.
`default_nettype none
module lookahead_steering_controller_core #(
    parameter int MAX_PATH_POINTS = lasc_pkg::MaxPathPoints
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, from bit 0: point_x[23:0], point_y[23:0], robot_x[23:0],
    // robot_y[23:0], robot_heading[15:0]
    input  wire logic [111:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, from bit 0: target_found, target_index[7:0], linear_speed[15:0],
    // angular_rate[18:0], path_empty, then zero pad
    output logic [47:0]       m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int IdxW = (MAX_PATH_POINTS > 1) ? $clog2(MAX_PATH_POINTS) : 1;
    localparam int LenW = $clog2(MAX_PATH_POINTS + 1);

    logic [23:0] look_reg;
    logic [15:0] steer_reg, gain_reg, cruise_reg;
    logic [LenW-1:0] len_reg;
    logic empty_reg;

    lasc_pkg::lasc_cmd_t cmd;
    lasc_pkg::lasc_sts_t sts;
    logic [IdxW-1:0] scan_idx;
    logic busy, ov;
    logic in_acc, start, wr_en;
    logic res_found;
    logic [7:0] res_index;
    logic [15:0] res_speed;
    logic signed [18:0] res_rate;

    assign s_axis_tready = !busy;
    assign cfg_ready     = 1'b1;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign start  = in_acc && (s_axis_tuser == lasc_pkg::OP_QUERY);
    assign wr_en  = in_acc && (s_axis_tuser == lasc_pkg::OP_APPEND)
                  && (len_reg < LenW'(MAX_PATH_POINTS));

    // Configuration registers and path length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_reg <= 24'd256; steer_reg <= 16'd8192;
            gain_reg <= 16'd256; cruise_reg <= 16'd128;
            len_reg <= '0; empty_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lasc_pkg::REG_LOOKAHEAD: look_reg   <= cfg_data[23:0];
                    lasc_pkg::REG_MAX_STEER: steer_reg  <= cfg_data[15:0];
                    lasc_pkg::REG_GAIN:      gain_reg   <= cfg_data[15:0];
                    lasc_pkg::REG_CRUISE:    cruise_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_acc && s_axis_tuser == lasc_pkg::OP_CLEAR)
                len_reg <= '0;
            else if (wr_en)
                len_reg <= len_reg + 1'b1;
            if (start)
                empty_reg <= (len_reg == '0);
        end
    end

    lasc_ctrl #(.IDX_W(IdxW), .LEN_W(LenW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .path_len(len_reg), .sts(sts),
        .out_taken(m_axis_tready), .cmd(cmd), .scan_idx(scan_idx), .busy(busy),
        .out_valid(ov)
    );

    lasc_datapath #(.DEPTH(MAX_PATH_POINTS), .IDX_W(IdxW)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(len_reg[IdxW-1:0]),
        .wr_x(s_axis_tdata[23:0]), .wr_y(s_axis_tdata[47:24]), .scan_idx(scan_idx),
        .robot_x(s_axis_tdata[71:48]), .robot_y(s_axis_tdata[95:72]),
        .robot_heading(s_axis_tdata[111:96]), .lookahead(look_reg),
        .max_steer(steer_reg), .gain(gain_reg), .cruise(cruise_reg), .cmd(cmd),
        .sts(sts), .res_found(res_found), .res_index(res_index),
        .res_speed(res_speed), .res_rate(res_rate)
    );

    assign m_axis_tvalid = ov;
    assign m_axis_tdata  = {3'b000, empty_reg, res_rate, res_speed, res_index,
                            res_found};

endmodule
`default_nettype wire

// ----- hw/rtl/lasc_checker.sv -----
// Port-level checker for the lookahead steering controller, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module lasc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [47:0]  m_axis_tdata
);

    // A result that is not taken stays.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new item is accepted while a result waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with pending result");

    // With no target, index, speed and rate are zero.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[43:1] == '0)
        else $error("nonzero command without target");

    // The input only goes busy after an offered transaction.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input stalled without a transaction");

endmodule

bind lookahead_steering_controller_core lasc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
